@@ hdl/ddf_pkg.sv @@
// shared widths, register indexes and word types of the detection decode filter
package ddf_pkg;

	localparam int CoordW   = 14;
	localparam int ScoreW   = 16;
	localparam int ProdW    = 2 * ScoreW;
	localparam int PixW     = 10;
	localparam int PadW     = 10;
	localparam int FrameW   = 11;
	localparam int ClassN   = 4;
	localparam int ClassW   = 2;
	localparam int SumW     = 18;
	localparam int CornerW  = 13;
	localparam int SubPixSh = 5;
	localparam int CfgIdxW  = 3;
	localparam int CfgDataW = 16;
	localparam int PixMax   = (1 << PixW) - 1;

	// register indexes of the configuration port
	typedef enum logic [CfgIdxW-1:0] {
		REG_SCORE_THR = 3'd0,
		REG_PAD_LEFT  = 3'd1,
		REG_PAD_TOP   = 3'd2,
		REG_FRAME_W   = 3'd3,
		REG_FRAME_H   = 3'd4
	} cfg_reg_t;

	localparam logic [ScoreW-1:0] ScoreThrReset = 16'd16384;
	localparam logic [PadW-1:0]   PadReset      = 10'd0;
	localparam logic [FrameW-1:0] FrameWReset   = 11'd640;
	localparam logic [FrameW-1:0] FrameHReset   = 11'd480;

	typedef logic signed [CornerW-1:0] corner_t;

	typedef struct packed {
		logic [ScoreW-1:0] score_thr;
		logic [PadW-1:0]   pad_left;
		logic [PadW-1:0]   pad_top;
		logic [FrameW-1:0] frame_width;
		logic [FrameW-1:0] frame_height;
	} cfg_t;

	// classified row travelling from the front part to the back part
	typedef struct packed {
		logic              obj_ok;
		logic [ClassW-1:0] class_id;
		logic [ScoreW-1:0] objectness;
		logic [ScoreW-1:0] best_score;
		corner_t           x_lo;
		corner_t           x_hi;
		corner_t           y_lo;
		corner_t           y_hi;
	} row_class_t;

endpackage

@@ hdl/ddf_ifs.sv @@
// valid/ready channel interfaces of the detection decode filter
interface ddf_row_if;
	import ddf_pkg::*;
	logic              valid;
	logic              ready;
	logic [CoordW-1:0] centre_x;
	logic [CoordW-1:0] centre_y;
	logic [CoordW-1:0] box_w;
	logic [CoordW-1:0] box_h;
	logic [ScoreW-1:0] objectness;
	logic [ScoreW-1:0] score_class0;
	logic [ScoreW-1:0] score_class1;
	logic [ScoreW-1:0] score_class2;
	logic [ScoreW-1:0] score_class3;

	modport source (output valid, centre_x, centre_y, box_w, box_h, objectness,
		score_class0, score_class1, score_class2, score_class3, input ready);
	modport sink (input valid, centre_x, centre_y, box_w, box_h, objectness,
		score_class0, score_class1, score_class2, score_class3, output ready);
endinterface

interface ddf_det_if;
	import ddf_pkg::*;
	logic              valid;
	logic              ready;
	logic              keep;
	logic [ClassW-1:0] class_id;
	logic [ScoreW-1:0] confidence;
	logic [PixW-1:0]   left;
	logic [PixW-1:0]   top;
	logic [PixW-1:0]   rect_width;
	logic [PixW-1:0]   rect_height;
	logic [PixW-1:0]   mid_x;
	logic [PixW-1:0]   mid_y;

	modport source (output valid, keep, class_id, confidence, left, top, rect_width,
		rect_height, mid_x, mid_y, input ready);
	modport sink (input valid, keep, class_id, confidence, left, top, rect_width,
		rect_height, mid_x, mid_y, output ready);
endinterface

interface ddf_cfg_if;
	import ddf_pkg::*;
	logic                valid;
	logic                ready;
	logic [CfgIdxW-1:0]  index;
	logic [CfgDataW-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

@@ hdl/detection_decode_filter.sv @@
// top level of the detection decode filter: registers, front part, queue and back part
//
// Usage
//   row : sink channel, one raw detector row per word (centre, size, objectness and
//         four class scores). A word moves when valid and ready are both high.
//   det : source channel, exactly one result word per row, in row order. keep is 0
//         for a dropped row and every other field is then zero.
//   cfg : write channel for the five registers (score threshold, padding, frame
//         size); always ready. The user must write them only while no row is
//         in flight; the block does not enforce it. Throughput: one row per cycle;
//   every stage takes a new word in the same cycle that it hands one on, and so does
//   the queue unless it is full, so nothing waits while det is ready.
//   Reset (arst_n low) empties all stages and the queue and loads the register
//   defaults: threshold 0.25, no padding, 640x480 frame.
//   A stall on det holds the result word; the back part, the queue and then the
//   front stage fill, and only then does row.ready fall.
module detection_decode_filter #(
	parameter int QUEUE_DEPTH = 2
) (
	input logic      clk,
	input logic      arst_n,
	ddf_row_if.sink  row,
	ddf_det_if.source det,
	ddf_cfg_if.sink  cfg
);
	import ddf_pkg::*;

	cfg_t       cfg_q;
	logic       push_valid, push_ready, pop_valid, pop_ready;
	row_class_t push_data, pop_data;

	assign cfg.ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.score_thr    <= ScoreThrReset;
			cfg_q.pad_left     <= PadReset;
			cfg_q.pad_top      <= PadReset;
			cfg_q.frame_width  <= FrameWReset;
			cfg_q.frame_height <= FrameHReset;
		end else if (cfg.valid) begin
			case (cfg_reg_t'(cfg.index))
				REG_SCORE_THR: cfg_q.score_thr    <= cfg.data[ScoreW-1:0];
				REG_PAD_LEFT:  cfg_q.pad_left     <= cfg.data[PadW-1:0];
				REG_PAD_TOP:   cfg_q.pad_top      <= cfg.data[PadW-1:0];
				REG_FRAME_W:   cfg_q.frame_width  <= cfg.data[FrameW-1:0];
				REG_FRAME_H:   cfg_q.frame_height <= cfg.data[FrameW-1:0];
				default: ;
			endcase
		end
	end

	ddf_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_regs   (cfg_q),
		.row        (row),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data)
	);

	ddf_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	ddf_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_regs  (cfg_q),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_data  (pop_data),
		.det       (det)
	);

endmodule

@@ hdl/ddf_front.sv @@
// front part: accepts a row, checks objectness, picks the class and forms the raw corners
module ddf_front (
	input  logic               clk,
	input  logic               arst_n,
	input  ddf_pkg::cfg_t      cfg_regs,
	ddf_row_if.sink            row,
	output logic               push_valid,
	input  logic               push_ready,
	output ddf_pkg::row_class_t push_data
);
	import ddf_pkg::*;

	// twice the difference of the centre and sixteen times the padding, in 1/32 pixel
	function automatic logic signed [SumW-1:0] centre2(input logic [CoordW-1:0] c,
		input logic [PadW-1:0] p);
		logic signed [SumW-1:0] d;
		d = $signed({{(SumW-CoordW){1'b0}}, c}) - $signed({{(SumW-PadW-4){1'b0}}, p, 4'b0});
		return d <<< 1;
	endfunction

	// division by 32 truncating toward zero
	function automatic corner_t trunc32(input logic signed [SumW-1:0] v);
		logic signed [SumW-1:0] b;
		b = v + $signed({{(SumW-SubPixSh){1'b0}}, {SubPixSh{v[SumW-1]}}});
		return corner_t'(b >>> SubPixSh);
	endfunction

	logic signed [SumW-1:0] cx2, cy2, w_s, h_s;
	logic signed [SumW-1:0] x_lo_raw, x_hi_raw, y_lo_raw, y_hi_raw;
	logic [ScoreW-1:0]      scores [ClassN];
	logic [ScoreW-1:0]      best;
	logic [ClassW-1:0]      cls;
	row_class_t             item_d;
	logic                   valid_s1;
	row_class_t             item_s1;

	// corner sums for both axes
	always_comb begin
		cx2      = centre2(row.centre_x, cfg_regs.pad_left);
		cy2      = centre2(row.centre_y, cfg_regs.pad_top);
		w_s      = $signed({{(SumW-CoordW){1'b0}}, row.box_w});
		h_s      = $signed({{(SumW-CoordW){1'b0}}, row.box_h});
		x_lo_raw = cx2 - w_s;
		x_hi_raw = cx2 + w_s;
		y_lo_raw = cy2 - h_s;
		y_hi_raw = cy2 + h_s;
	end

	// first maximal class score, lowest index wins on ties
	always_comb begin
		scores[0] = row.score_class0;
		scores[1] = row.score_class1;
		scores[2] = row.score_class2;
		scores[3] = row.score_class3;
		best      = scores[0];
		cls       = '0;
		for (int k = 1; k < ClassN; k++) begin
			if (scores[k] > best) begin
				best = scores[k];
				cls  = ClassW'(k);
			end
		end
	end

	// classified word; a negative low corner clamps to zero
	always_comb begin
		item_d.obj_ok     = row.objectness >= cfg_regs.score_thr;
		item_d.class_id   = cls;
		item_d.objectness = row.objectness;
		item_d.best_score = best;
		item_d.x_lo       = x_lo_raw[SumW-1] ? '0 : trunc32(x_lo_raw);
		item_d.x_hi       = trunc32(x_hi_raw);
		item_d.y_lo       = y_lo_raw[SumW-1] ? '0 : trunc32(y_lo_raw);
		item_d.y_hi       = trunc32(y_hi_raw);
	end

	assign row.ready  = !valid_s1 || push_ready;
	assign push_valid = valid_s1;
	assign push_data  = item_s1;

	// stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (row.ready) begin
			valid_s1 <= row.valid;
		end
	end

	// stage word
	always_ff @(posedge clk) begin
		if (row.valid && row.ready) begin
			item_s1 <= item_d;
		end
	end

endmodule

@@ hdl/ddf_queue.sv @@
// short first-in first-out queue between the front and back parts
module ddf_queue #(
	parameter int DEPTH = 2
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push_valid,
	output logic                push_ready,
	input  ddf_pkg::row_class_t push_data,
	output logic                pop_valid,
	input  logic                pop_ready,
	output ddf_pkg::row_class_t pop_data
);
	import ddf_pkg::*;

	localparam int PtrW = $clog2(DEPTH);
	localparam int CntW = $clog2(DEPTH + 1);

	function automatic logic [PtrW-1:0] bump(input logic [PtrW-1:0] p);
		return (p == PtrW'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	row_class_t      mem_q [DEPTH];
	logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CntW-1:0] count_q;
	logic            do_push, do_pop;

	assign push_ready = count_q < CntW'(DEPTH);
	assign pop_valid  = count_q != '0;
	assign pop_data   = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) wr_ptr_q <= bump(wr_ptr_q);
			if (do_pop)  rd_ptr_q <= bump(rd_ptr_q);
			if (do_push && !do_pop)      count_q <= count_q + 1'b1;
			else if (!do_push && do_pop) count_q <= count_q - 1'b1;
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CntW'(DEPTH))
		else $error("queue count beyond depth");

endmodule

@@ hdl/ddf_back.sv @@
// back part: multiplies scores, clamps corners to the frame and registers the result word
module ddf_back (
	input  logic                clk,
	input  logic                arst_n,
	input  ddf_pkg::cfg_t       cfg_regs,
	input  logic                pop_valid,
	output logic                pop_ready,
	input  ddf_pkg::row_class_t pop_data,
	ddf_det_if.source           det
);
	import ddf_pkg::*;

	// right or bottom limit: min(frame - 1, 1023)
	function automatic corner_t clamp_limit(input logic [FrameW-1:0] frame);
		corner_t l;
		l = $signed({{(CornerW-FrameW){1'b0}}, frame}) - corner_t'(1);
		if (l > corner_t'(PixMax)) l = corner_t'(PixMax);
		return l;
	endfunction

	logic              valid_s1, valid_s2, free_s1, free_s2;
	logic [ProdW-1:0]  prod_s1;
	logic              obj_ok_s1;
	logic [ClassW-1:0] class_s1;
	corner_t           x_lo_s1, x_hi_s1, y_lo_s1, y_hi_s1;
	corner_t           x_lim, y_lim;
	corner_t           rw_full, rh_full;
	logic              keep_d;
	logic [PixW-1:0]   rw_d, rh_d;

	logic              keep_s2;
	logic [ClassW-1:0] class_s2;
	logic [ScoreW-1:0] conf_s2;
	logic [PixW-1:0]   left_s2, top_s2, rw_s2, rh_s2, mid_x_s2, mid_y_s2;

	assign free_s2   = !valid_s2 || det.ready;
	assign free_s1   = !valid_s1 || free_s2;
	assign pop_ready = free_s1;

	assign x_lim = clamp_limit(cfg_regs.frame_width);
	assign y_lim = clamp_limit(cfg_regs.frame_height);

	// threshold on the product and inversion check
	always_comb begin
		rw_full = x_hi_s1 - x_lo_s1;
		rh_full = y_hi_s1 - y_lo_s1;
		keep_d  = obj_ok_s1 && (prod_s1 > {cfg_regs.score_thr, {ScoreW{1'b0}}})
			&& (x_hi_s1 >= x_lo_s1) && (y_hi_s1 >= y_lo_s1);
		rw_d    = rw_full[PixW-1:0];
		rh_d    = rh_full[PixW-1:0];
	end

	// stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (free_s1) valid_s1 <= pop_valid;
			if (free_s2) valid_s2 <= valid_s1;
		end
	end

	// multiply and clamp stage
	always_ff @(posedge clk) begin
		if (pop_valid && free_s1) begin
			prod_s1   <= pop_data.objectness * pop_data.best_score;
			obj_ok_s1 <= pop_data.obj_ok;
			class_s1  <= pop_data.class_id;
			x_lo_s1   <= pop_data.x_lo;
			y_lo_s1   <= pop_data.y_lo;
			x_hi_s1   <= (pop_data.x_hi > x_lim) ? x_lim : pop_data.x_hi;
			y_hi_s1   <= (pop_data.y_hi > y_lim) ? y_lim : pop_data.y_hi;
		end
	end

	// result register, all fields zero on a dropped row
	always_ff @(posedge clk) begin
		if (valid_s1 && free_s2) begin
			keep_s2  <= keep_d;
			class_s2 <= keep_d ? class_s1 : '0;
			conf_s2  <= keep_d ? prod_s1[ProdW-1:ScoreW] : '0;
			left_s2  <= keep_d ? x_lo_s1[PixW-1:0] : '0;
			top_s2   <= keep_d ? y_lo_s1[PixW-1:0] : '0;
			rw_s2    <= keep_d ? rw_d : '0;
			rh_s2    <= keep_d ? rh_d : '0;
			mid_x_s2 <= keep_d ? x_lo_s1[PixW-1:0] + (rw_d >> 1) : '0;
			mid_y_s2 <= keep_d ? y_lo_s1[PixW-1:0] + (rh_d >> 1) : '0;
		end
	end

	assign det.valid       = valid_s2;
	assign det.keep        = keep_s2;
	assign det.class_id    = class_s2;
	assign det.confidence  = conf_s2;
	assign det.left        = left_s2;
	assign det.top         = top_s2;
	assign det.rect_width  = rw_s2;
	assign det.rect_height = rh_s2;
	assign det.mid_x       = mid_x_s2;
	assign det.mid_y       = mid_y_s2;

	a_drop_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && !keep_s2) |-> (class_s2 == '0 && conf_s2 == '0 && left_s2 == '0
			&& top_s2 == '0 && rw_s2 == '0 && rh_s2 == '0))
		else $error("dropped word carries non-zero fields");

	a_conf_thr: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && keep_s2) |-> (conf_s2 >= cfg_regs.score_thr))
		else $error("kept word below threshold");

	a_box_fits: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && keep_s2) |->
			(({1'b0, left_s2} + {1'b0, rw_s2}) <= (PixW+1)'(PixMax)
			&& ({1'b0, top_s2} + {1'b0, rh_s2}) <= (PixW+1)'(PixMax)))
		else $error("kept box leaves the frame");

endmodule

@@ tb/tb_top.sv @@
// self-checking testbench of the detection decode filter
module tb_top;
	import ddf_pkg::*;

	localparam int CycleLimit = 200000;
	localparam int IdlePct    = 38;
	localparam int SqueezeLen = 200;
	localparam int SettleLen  = 8;
	localparam int MaxReports = 10;
	localparam int ScoreMax   = (1 << ScoreW) - 1;
	localparam int CoordMax   = (1 << CoordW) - 1;
	localparam logic [CfgIdxW-1:0] RegUnmapped = 3'd7;

	typedef struct packed {
		logic [CoordW-1:0] centre_x;
		logic [CoordW-1:0] centre_y;
		logic [CoordW-1:0] box_w;
		logic [CoordW-1:0] box_h;
		logic [ScoreW-1:0] objectness;
		logic [ScoreW-1:0] score_class0;
		logic [ScoreW-1:0] score_class1;
		logic [ScoreW-1:0] score_class2;
		logic [ScoreW-1:0] score_class3;
	} row_word_t;

	typedef struct packed {
		logic              keep;
		logic [ClassW-1:0] class_id;
		logic [ScoreW-1:0] confidence;
		logic [PixW-1:0]   left;
		logic [PixW-1:0]   top;
		logic [PixW-1:0]   rect_width;
		logic [PixW-1:0]   rect_height;
		logic [PixW-1:0]   mid_x;
		logic [PixW-1:0]   mid_y;
	} det_word_t;

	// decodes accepted rows and holds the detections still due from the block
	class detection_ledger;
		det_word_t due_dets[$];
		int        rows_noted;
		int        dets_checked;
		int        dets_kept;
		int        faults;

		// one axis: signed corners in 1/32 pixel, truncated, clamped to the frame
		function bit axis_span(logic [CoordW-1:0] centre, logic [CoordW-1:0] size,
				logic [PadW-1:0] pad, logic [FrameW-1:0] frame, output int lo, output int hi);
			int c2;
			int lim;
			c2 = 2 * (int'(centre) - 16 * int'(pad));
			lo = (c2 - int'(size)) / 32;
			hi = (c2 + int'(size)) / 32;
			lim = int'(frame) - 1;
			if (lim > PixMax)
				lim = PixMax;
			if (lo < 0)
				lo = 0;
			if (hi > lim)
				hi = lim;
			return hi >= lo;
		endfunction

		function det_word_t decode_row(row_word_t r, cfg_t c);
			det_word_t         d;
			logic [ScoreW-1:0] scores [ClassN];
			logic [ScoreW-1:0] best;
			logic [ClassW-1:0] cls;
			logic [ProdW-1:0]  prod;
			int                x_lo, x_hi, y_lo, y_hi;
			int                rw, rh;
			d = '0;
			if (r.objectness < c.score_thr)
				return d;
			scores[0] = r.score_class0;
			scores[1] = r.score_class1;
			scores[2] = r.score_class2;
			scores[3] = r.score_class3;
			// first maximum wins on ties
			best = scores[0];
			cls = '0;
			for (int k = 1; k < ClassN; k++) begin
				if (scores[k] > best) begin
					best = scores[k];
					cls = ClassW'(k);
				end
			end
			prod = ProdW'(r.objectness) * ProdW'(best);
			if (prod <= {c.score_thr, {ScoreW{1'b0}}})
				return d;
			if (!axis_span(r.centre_x, r.box_w, c.pad_left, c.frame_width, x_lo, x_hi))
				return d;
			if (!axis_span(r.centre_y, r.box_h, c.pad_top, c.frame_height, y_lo, y_hi))
				return d;
			rw = x_hi - x_lo;
			rh = y_hi - y_lo;
			d.keep        = 1'b1;
			d.class_id    = cls;
			d.confidence  = prod[ProdW-1:ScoreW];
			d.left        = PixW'(x_lo);
			d.top         = PixW'(y_lo);
			d.rect_width  = PixW'(rw);
			d.rect_height = PixW'(rh);
			d.mid_x       = PixW'(x_lo + rw / 2);
			d.mid_y       = PixW'(y_lo + rh / 2);
			return d;
		endfunction

		function void note_row(row_word_t r, cfg_t c);
			due_dets = {due_dets, decode_row(r, c)};
			rows_noted++;
		endfunction

		function string describe(det_word_t d);
			return $sformatf("keep %0d class %0d conf %h box %0d,%0d %0dx%0d mid %0d,%0d",
				d.keep, d.class_id, d.confidence, d.left, d.top, d.rect_width,
				d.rect_height, d.mid_x, d.mid_y);
		endfunction

		function void check_det(det_word_t got);
			det_word_t want;
			string     diffs;
			diffs = "";
			if (due_dets.size() == 0) begin
				if (faults < MaxReports)
					$display("unexpected detection word: %s", describe(got));
				faults++;
				return;
			end
			want = due_dets.pop_front();
			dets_checked++;
			if (want.keep)
				dets_kept++;
			if (got.keep !== want.keep)               diffs = {diffs, " keep"};
			if (got.class_id !== want.class_id)       diffs = {diffs, " class_id"};
			if (got.confidence !== want.confidence)   diffs = {diffs, " confidence"};
			if (got.left !== want.left)               diffs = {diffs, " left"};
			if (got.top !== want.top)                 diffs = {diffs, " top"};
			if (got.rect_width !== want.rect_width)   diffs = {diffs, " rect_width"};
			if (got.rect_height !== want.rect_height) diffs = {diffs, " rect_height"};
			if (got.mid_x !== want.mid_x)             diffs = {diffs, " mid_x"};
			if (got.mid_y !== want.mid_y)             diffs = {diffs, " mid_y"};
			if (diffs != "") begin
				if (faults < MaxReports) begin
					$display("detection %0d differs in%s", dets_checked - 1, diffs);
					$display("  wanted %s", describe(want));
					$display("  got    %s", describe(got));
				end
				faults++;
			end
		endfunction

		function int pending();
			return due_dets.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;

	ddf_row_if row_ch ();
	ddf_det_if det_ch ();
	ddf_cfg_if cfg_ch ();

	detection_decode_filter i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.row    (row_ch),
		.det    (det_ch),
		.cfg    (cfg_ch)
	);

	detection_ledger ledger;
	cfg_t            shadow_cfg;
	bit              steady;
	int              squeeze_asks;
	int              cycle_count;
	int              reg_writes;
	int              settings_seen;

	// clock
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// run limit
	initial begin
		cycle_count = 0;
		while (cycle_count < CycleLimit) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("timeout after %0d cycles, %0d detections still due", cycle_count,
			ledger.pending());
		$display("status: fail");
		$finish;
	end

	// result side: check each accepted word, then pick the next ready
	initial begin
		int        hold_left;
		int        squeezes_done;
		det_word_t got;
		hold_left = 0;
		squeezes_done = 0;
		det_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (det_ch.valid && det_ch.ready) begin
				got.keep        = det_ch.keep;
				got.class_id    = det_ch.class_id;
				got.confidence  = det_ch.confidence;
				got.left        = det_ch.left;
				got.top         = det_ch.top;
				got.rect_width  = det_ch.rect_width;
				got.rect_height = det_ch.rect_height;
				got.mid_x       = det_ch.mid_x;
				got.mid_y       = det_ch.mid_y;
				ledger.check_det(got);
			end
			if (squeeze_asks != squeezes_done) begin
				squeezes_done = squeeze_asks;
				hold_left = SqueezeLen;
			end
			if (hold_left > 0) begin
				hold_left--;
				det_ch.ready <= 1'b0;
			end else if (steady) begin
				det_ch.ready <= 1'b1;
			end else begin
				det_ch.ready <= ($urandom_range(0, 99) >= IdlePct);
			end
		end
	end

	function automatic logic [CoordW-1:0] sat_coord(longint v);
		if (v < 0)
			return '0;
		if (v > CoordMax)
			return '1;
		return CoordW'(v);
	endfunction

	function automatic logic [ScoreW-1:0] sat_score(longint v);
		if (v < 0)
			return '0;
		if (v > ScoreMax)
			return '1;
		return ScoreW'(v);
	endfunction

	function automatic row_word_t row_of(int cx, int cy, int w, int h, int obj,
			int s0, int s1, int s2, int s3);
		row_word_t r;
		r.centre_x     = CoordW'(cx);
		r.centre_y     = CoordW'(cy);
		r.box_w        = CoordW'(w);
		r.box_h        = CoordW'(h);
		r.objectness   = ScoreW'(obj);
		r.score_class0 = ScoreW'(s0);
		r.score_class1 = ScoreW'(s1);
		r.score_class2 = ScoreW'(s2);
		r.score_class3 = ScoreW'(s3);
		return r;
	endfunction

	// mostly plausible detections inside the padded frame, some near the
	// threshold boundary, the rest pure noise
	function automatic row_word_t random_row(cfg_t c);
		row_word_t r;
		int        pick;
		int        thr;
		int        fw, fh;
		int        lead;
		longint    need;
		pick = $urandom_range(0, 99);
		r.centre_x     = CoordW'($urandom);
		r.centre_y     = CoordW'($urandom);
		r.box_w        = CoordW'($urandom);
		r.box_h        = CoordW'($urandom);
		r.objectness   = ScoreW'($urandom);
		r.score_class0 = ScoreW'($urandom);
		r.score_class1 = ScoreW'($urandom);
		r.score_class2 = ScoreW'($urandom);
		r.score_class3 = ScoreW'($urandom);
		if (pick < 15)
			return r;
		thr = int'(c.score_thr);
		fw = int'(c.frame_width);
		fh = int'(c.frame_height);
		if (pick < 32) begin
			// product right at the threshold
			r.objectness = sat_score(longint'(thr) + $urandom_range(0, 4) - 2);
			need = (r.objectness == 0) ? 0 : (longint'(thr) << ScoreW) / r.objectness;
			r.score_class0 = sat_score(need + $urandom_range(0, 2) - 1);
			r.score_class1 = ScoreW'($urandom_range(0, r.score_class0));
			r.score_class2 = ScoreW'($urandom_range(0, r.score_class0));
			r.score_class3 = ScoreW'($urandom_range(0, r.score_class0));
		end else begin
			r.objectness = ScoreW'($urandom_range(thr, ScoreMax));
			lead = $urandom_range(0, ClassN - 1);
			case (lead)
				0: r.score_class0 = ScoreW'($urandom_range(ScoreMax / 2, ScoreMax));
				1: r.score_class1 = ScoreW'($urandom_range(ScoreMax / 2, ScoreMax));
				2: r.score_class2 = ScoreW'($urandom_range(ScoreMax / 2, ScoreMax));
				default: r.score_class3 = ScoreW'($urandom_range(ScoreMax / 2, ScoreMax));
			endcase
			// ties between classes
			if ($urandom_range(0, 4) == 0)
				r.score_class2 = r.score_class1;
			if ($urandom_range(0, 4) == 0)
				r.score_class3 = r.score_class0;
		end
		r.centre_x = sat_coord(16 * (longint'(c.pad_left) + $urandom_range(0, fw))
			+ $urandom_range(0, 15));
		r.centre_y = sat_coord(16 * (longint'(c.pad_top) + $urandom_range(0, fh))
			+ $urandom_range(0, 15));
		if ($urandom_range(0, 3) == 0) begin
			r.box_w = CoordW'($urandom);
			r.box_h = CoordW'($urandom);
		end else begin
			r.box_w = sat_coord($urandom_range(0, 8 * fw + 16));
			r.box_h = sat_coord($urandom_range(0, 8 * fh + 16));
		end
		return r;
	endfunction

	function automatic logic [CfgDataW-1:0] with_stray_bits(int v, int w);
		logic [CfgDataW-1:0] junk;
		junk = CfgDataW'($urandom) << w;
		return junk | CfgDataW'(v);
	endfunction

	// one row word, after a random number of idle cycles unless steady is set
	task automatic send_row(row_word_t r);
		if (!steady) begin
			while ($urandom_range(0, 99) < IdlePct) begin
				row_ch.valid <= 1'b0;
				@(posedge clk);
			end
		end
		row_ch.valid        <= 1'b1;
		row_ch.centre_x     <= r.centre_x;
		row_ch.centre_y     <= r.centre_y;
		row_ch.box_w        <= r.box_w;
		row_ch.box_h        <= r.box_h;
		row_ch.objectness   <= r.objectness;
		row_ch.score_class0 <= r.score_class0;
		row_ch.score_class1 <= r.score_class1;
		row_ch.score_class2 <= r.score_class2;
		row_ch.score_class3 <= r.score_class3;
		do @(posedge clk); while (!row_ch.ready);
		ledger.note_row(r, shadow_cfg);
	endtask

	// one register write word
	task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] value);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= value;
		do @(posedge clk); while (!cfg_ch.ready);
		case (idx)
			REG_SCORE_THR: shadow_cfg.score_thr    = value;
			REG_PAD_LEFT:  shadow_cfg.pad_left     = PadW'(value);
			REG_PAD_TOP:   shadow_cfg.pad_top      = PadW'(value);
			REG_FRAME_W:   shadow_cfg.frame_width  = FrameW'(value);
			REG_FRAME_H:   shadow_cfg.frame_height = FrameW'(value);
			default: ;
		endcase
		reg_writes++;
		cfg_ch.valid <= 1'b0;
		@(posedge clk);
	endtask

	// wait for every due detection, then let the pipeline settle
	task automatic wait_idle();
		row_ch.valid <= 1'b0;
		while (ledger.pending() > 0) @(posedge clk);
		repeat (SettleLen) @(posedge clk);
	endtask

	task automatic apply_settings(int thr, int pl, int pt, int fw, int fh);
		write_reg(REG_SCORE_THR, CfgDataW'(thr));
		write_reg(REG_PAD_LEFT, with_stray_bits(pl, PadW));
		write_reg(REG_PAD_TOP, with_stray_bits(pt, PadW));
		write_reg(REG_FRAME_W, with_stray_bits(fw, FrameW));
		write_reg(REG_FRAME_H, with_stray_bits(fh, FrameW));
		settings_seen++;
	endtask

	// stimulus
	initial begin
		int thr_tab [9];
		int pl_tab [9];
		int pt_tab [9];
		int fw_tab [9];
		int fh_tab [9];
		int len_tab [9];
		int thr, pl, pt, fw, fh;
		thr_tab = '{16384, -1, 0, 65535, 1, -1, -1, 16384, -1};
		pl_tab  = '{0, -1, 0, 512, 1023, -1, -1, 512, -1};
		pt_tab  = '{0, -1, 0, 512, 1023, -1, -1, 0, -1};
		fw_tab  = '{640, -1, 1024, 1, 2047, -1, -1, 1024, -1};
		fh_tab  = '{480, -1, 1024, 1, 2047, -1, -1, 1, -1};
		len_tab = '{260, 260, 240, 60, 240, 250, 250, 200, 200};
		ledger = new;
		steady = 1'b0;
		squeeze_asks = 0;
		reg_writes = 0;
		settings_seen = 1;
		arst_n              <= 1'b0;
		row_ch.valid        <= 1'b0;
		row_ch.centre_x     <= '0;
		row_ch.centre_y     <= '0;
		row_ch.box_w        <= '0;
		row_ch.box_h        <= '0;
		row_ch.objectness   <= '0;
		row_ch.score_class0 <= '0;
		row_ch.score_class1 <= '0;
		row_ch.score_class2 <= '0;
		row_ch.score_class3 <= '0;
		cfg_ch.valid        <= 1'b0;
		cfg_ch.index        <= '0;
		cfg_ch.data         <= '0;
		shadow_cfg.score_thr    = ScoreThrReset;
		shadow_cfg.pad_left     = PadReset;
		shadow_cfg.pad_top      = PadReset;
		shadow_cfg.frame_width  = FrameWReset;
		shadow_cfg.frame_height = FrameHReset;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed rows on the reset defaults
		send_row(row_of(0, 0, 0, 0, 0, 0, 0, 0, 0));
		send_row(row_of(16383, 16383, 16383, 16383, 65535, 65535, 65535, 65535, 65535));
		send_row(row_of(1600, 1600, 320, 320, 16383, 65535, 0, 0, 0));
		send_row(row_of(1600, 1600, 320, 320, 16384, 65535, 0, 0, 0));
		send_row(row_of(1600, 1600, 320, 320, 32768, 32768, 0, 0, 0));
		send_row(row_of(1600, 1600, 320, 320, 32768, 32769, 0, 0, 0));
		send_row(row_of(3200, 2400, 800, 640, 65535, 40000, 40000, 40000, 40000));
		send_row(row_of(3200, 2400, 800, 640, 65535, 100, 50000, 200, 50000));
		send_row(row_of(3200, 2400, 800, 640, 65535, 100, 200, 60000, 300));
		send_row(row_of(3200, 2400, 800, 640, 65535, 100, 200, 300, 61000));
		send_row(row_of(0, 8, 31, 100, 60000, 60000, 0, 0, 0));
		send_row(row_of(100, 100, 3000, 3000, 60000, 60000, 0, 0, 0));
		send_row(row_of(11200, 1600, 16, 16, 60000, 60000, 0, 0, 0));
		send_row(row_of(1600, 7664, 16, 64, 60000, 60000, 0, 0, 0));
		send_row(row_of(333, 333, 77, 77, 60000, 60000, 0, 0, 0));
		send_row(row_of(1600, 1600, 0, 0, 60000, 60000, 0, 0, 0));
		wait_idle();

		// zero threshold: a zero product still drops the row
		write_reg(REG_SCORE_THR, '0);
		send_row(row_of(1600, 1600, 320, 320, 0, 0, 0, 0, 0));
		send_row(row_of(1600, 1600, 320, 320, 1, 1, 0, 0, 0));
		wait_idle();

		// zero frame width drops every row
		write_reg(REG_FRAME_W, '0);
		send_row(row_of(1600, 1600, 320, 320, 60000, 60000, 0, 0, 0));
		wait_idle();

		// oversized frame and padding
		write_reg(REG_FRAME_W, CfgDataW'(2047));
		write_reg(REG_FRAME_H, CfgDataW'(1024));
		write_reg(REG_PAD_LEFT, CfgDataW'(1023));
		write_reg(REG_PAD_TOP, CfgDataW'(512));
		send_row(row_of(16383, 16383, 16383, 16383, 60000, 60000, 0, 0, 0));
		send_row(row_of(0, 0, 16383, 16383, 60000, 60000, 0, 0, 0));
		send_row(row_of(16383, 16383, 40, 40, 60000, 60000, 0, 0, 0));
		wait_idle();

		// a write to an unmapped index must leave the registers alone
		write_reg(RegUnmapped, CfgDataW'($urandom));
		send_row(row_of(16383, 12000, 500, 500, 60000, 60000, 0, 0, 0));
		wait_idle();

		// random phases, each under its own register setting
		for (int p = 0; p < 9; p++) begin
			thr = (thr_tab[p] < 0) ? $urandom_range(0, 49152) : thr_tab[p];
			pl  = (pl_tab[p] < 0) ? $urandom_range(0, 512) : pl_tab[p];
			pt  = (pt_tab[p] < 0) ? $urandom_range(0, 512) : pt_tab[p];
			fw  = (fw_tab[p] < 0) ? $urandom_range(1, 1024) : fw_tab[p];
			fh  = (fh_tab[p] < 0) ? $urandom_range(1, 1024) : fh_tab[p];
			apply_settings(thr, pl, pt, fw, fh);
			steady = (p == 0);
			for (int i = 0; i < len_tab[p]; i++) begin
				// long receiver hold-off while rows keep coming
				if (p == 1 && i == 40)
					squeeze_asks++;
				send_row(random_row(shadow_cfg));
			end
			wait_idle();
		end
		steady = 1'b0;

		$display("covered %0d rows under %0d register settings with %0d register writes",
			ledger.rows_noted, settings_seen, reg_writes);
		$display("%0d detections checked, %0d kept, %0d faults", ledger.dets_checked,
			ledger.dets_kept, ledger.faults);
		if (ledger.faults == 0 && ledger.pending() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
